>>> design/olde_pkg.sv
// Shared types, widths and codes of the ordered list delete engine.
package olde_pkg;

    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 3;
    localparam int DEPTH_DEF = 16;

    typedef logic        [FUNC_W-1:0] t_func;
    typedef logic        [STAT_W-1:0] t_status;
    typedef logic signed [DATA_W-1:0] t_data;

    localparam t_func FN_APPEND   = 3'd0;
    localparam t_func FN_RM_HEAD  = 3'd1;
    localparam t_func FN_RM_TAIL  = 3'd2;
    localparam t_func FN_RM_MATCH = 3'd3;
    localparam t_func FN_DUMP     = 3'd4;

    localparam t_status ST_DONE     = 3'd0;
    localparam t_status ST_EMPTY    = 3'd1;
    localparam t_status ST_FULL     = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_DUMP     = 3'd4;
    localparam t_status ST_DUMPNONE = 3'd5;

endpackage

>>> design/olde_if.sv
// Valid/ready channel interfaces for command words and result words.
interface olde_in_if;
    import olde_pkg::*;
    logic  valid;
    logic  ready;
    t_func func;
    t_data operand;
    modport source(output valid, func, operand, input ready);
    modport sink(input valid, func, operand, output ready);
endinterface

interface olde_out_if;
    import olde_pkg::*;
    logic    valid;
    logic    ready;
    t_status status;
    t_data   entry;
    logic    last;
    modport source(output valid, status, entry, last, input ready);
    modport sink(input valid, status, entry, last, output ready);
endinterface

>>> design/olde_ram.sv
// Entry store: one write port, one registered read port.
module olde_ram #(
    parameter int DEPTH = olde_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  olde_pkg::t_data i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output olde_pkg::t_data o_rdata
);
    import olde_pkg::*;

    t_data r_mem [DEPTH];
    t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/olde_seq.sv
// Command sequencer: walks the entry store, closes gaps, drives the result register.
module olde_seq #(
    parameter int DEPTH = olde_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    olde_in_if.sink         i_in,
    olde_out_if.source      o_out,
    output logic            o_we,
    output logic [AW-1:0]   o_waddr,
    output olde_pkg::t_data o_wdata,
    output logic            o_re,
    output logic [AW-1:0]   o_raddr,
    input  olde_pkg::t_data i_rdata
);
    import olde_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMD   = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DUMP  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]    r_state, n_state;
    t_func         r_func, n_func;
    t_data         r_operand, n_operand;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_idx, n_idx;
    t_status       r_pend, n_pend;

    logic          r_ovalid;
    t_status       r_ostatus;
    t_data         r_oentry;
    logic          r_olast;

    logic          emit;
    t_status       e_status;
    t_data         e_entry;
    logic          e_last;
    logic          can_emit;
    logic          empty, full;
    logic [XW-1:0] idx_p1, idx_p2, cnt_x;

    assign can_emit = !r_ovalid || o_out.ready;
    assign empty    = (r_cnt == '0);
    assign full     = (r_cnt == CW'(DEPTH));
    assign idx_p1   = XW'(r_idx) + XW'(1);
    assign idx_p2   = XW'(r_idx) + XW'(2);
    assign cnt_x    = XW'(r_cnt);

    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_operand = r_operand;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_pend    = r_pend;
        emit      = 1'b0;
        e_status  = ST_DONE;
        e_entry   = '0;
        e_last    = 1'b1;
        o_we      = 1'b0;
        o_waddr   = r_idx;
        o_wdata   = r_operand;
        o_re      = 1'b0;
        o_raddr   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_func    = i_in.func;
                    n_operand = i_in.operand;
                    n_state   = S_CMD;
                end
            end
            S_CMD: begin
                n_state = S_EMIT;
                n_pend  = ST_DONE;
                case (r_func)
                    FN_APPEND: begin
                        if (full) begin
                            n_pend = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = AW'(r_cnt);
                            n_cnt   = r_cnt + CW'(1);
                        end
                    end
                    FN_RM_HEAD: begin
                        if (empty) begin
                            n_pend = ST_EMPTY;
                        end else begin
                            // shift everything up from the head
                            n_idx   = '0;
                            o_re    = (r_cnt > CW'(1));
                            o_raddr = AW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                    FN_RM_TAIL: begin
                        if (empty) begin
                            n_pend = ST_EMPTY;
                        end else begin
                            n_cnt = r_cnt - CW'(1);
                        end
                    end
                    FN_RM_MATCH: begin
                        if (empty) begin
                            n_pend = ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            o_re    = 1'b1;
                            o_raddr = '0;
                            n_state = S_SRCH;
                        end
                    end
                    FN_DUMP: begin
                        if (empty) begin
                            n_pend = ST_DUMPNONE;
                        end else begin
                            n_idx   = '0;
                            o_re    = 1'b1;
                            o_raddr = '0;
                            n_state = S_DUMP;
                        end
                    end
                    default: begin
                        n_pend = ST_DONE;
                    end
                endcase
            end
            S_SRCH: begin
                if (i_rdata == r_operand) begin
                    // prefetch the entry that moves into the gap
                    o_re    = (idx_p1 < cnt_x);
                    o_raddr = r_idx + AW'(1);
                    n_state = S_SHIFT;
                end else if (idx_p1 == cnt_x) begin
                    n_pend  = ST_NOTFOUND;
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    o_re    = 1'b1;
                    o_raddr = r_idx + AW'(1);
                end
            end
            S_SHIFT: begin
                // write slot idx with entry idx+1 while fetching idx+2
                if (idx_p1 < cnt_x) begin
                    o_we    = 1'b1;
                    o_waddr = r_idx;
                    o_wdata = i_rdata;
                    n_idx   = r_idx + AW'(1);
                    o_re    = (idx_p2 < cnt_x);
                    o_raddr = r_idx + AW'(2);
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_pend  = ST_DONE;
                    n_state = S_EMIT;
                end
            end
            S_DUMP: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_status = ST_DUMP;
                    e_entry  = i_rdata;
                    e_last   = (idx_p1 == cnt_x);
                    if (idx_p1 == cnt_x) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        o_re    = 1'b1;
                        o_raddr = r_idx + AW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    emit     = 1'b1;
                    e_status = r_pend;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_operand <= n_operand;
        r_idx     <= n_idx;
        r_pend    <= n_pend;
        if (emit) begin
            r_ostatus <= e_status;
            r_oentry  <= e_entry;
            r_olast   <= e_last;
        end
    end

    assign o_out.valid  = r_ovalid;
    assign o_out.status = r_ostatus;
    assign o_out.entry  = r_oentry;
    assign o_out.last   = r_olast;

endmodule

>>> design/ordered_list_delete_engine_unit.sv
// Top level of the ordered list delete engine.
// Holds an ordered list of up to DEPTH signed 32-bit values in a single-port-write,
// registered-read store and takes one command word at a time. Append, remove tail
// and unknown commands pass from acceptance through a command state to a result
// state that loads the result word. Remove head walks the store to close the gap,
// remove first match searches up to the match and then closes the gap, and a dump
// offers one result word per cycle while the output is not stalled; the search and
// gap walks step one entry per cycle. The next command word is taken in the cycle
// after the last result word of a command is loaded. A result word waits in an
// output register while the next command word may already be taken; a stalled
// result holds a dump walk and the final result of any command until it is taken.
module ordered_list_delete_engine_unit #(
    parameter int DEPTH = olde_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olde_in_if.sink    i_in,
    olde_out_if.source o_out
);
    import olde_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    t_data         wdata, rdata;

    olde_seq #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    olde_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
